// ----- rtl/tspa_pkg.sv -----
package tspa_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'h47;
	localparam logic [7:0] BASE_SIZE    = 8'd188;
	localparam logic [7:0] MAX_SIZE     = 8'd208;
	localparam int         WINDOW_BYTES = 512;
	localparam int         NUM_TAPS     = 4;

	// pin the packet size into the supported range
	function automatic logic [7:0] clamp_size(input logic [7:0] raw);
		logic [7:0] ps;
		ps = raw;
		if (raw < BASE_SIZE) begin
			ps = BASE_SIZE;
		end else if (raw > MAX_SIZE) begin
			ps = MAX_SIZE;
		end
		return ps;
	endfunction

	// offset of the sync byte inside a packet
	function automatic logic [8:0] hdr_offset(input logic [7:0] ps);
		return 9'(ps) - 9'(BASE_SIZE);
	endfunction

	// sync byte of the following packet
	function automatic logic [8:0] next_offset(input logic [7:0] ps);
		return 9'({ps, 1'b0}) - 9'(BASE_SIZE);
	endfunction

	// sync byte of the packet after that
	function automatic logic [8:0] third_offset(input logic [7:0] ps);
		logic [9:0] sum;
		sum = 10'({ps, 1'b0}) + 10'(ps) - 10'(BASE_SIZE);
		return sum[8:0];
	endfunction

	// bytes needed for the three-packet search check
	function automatic logic [8:0] need_bytes(input logic [7:0] ps);
		logic [9:0] sum;
		sum = 10'({ps, 1'b0}) + 10'(ps) - 10'(BASE_SIZE) + 10'd1;
		return sum[8:0];
	endfunction

endpackage

// ----- rtl/tspa_ram.sv -----
module tspa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/tspa_tap.sv -----
// One read port on the window: a RAM copy read ahead at the next-state address, with
// forwarding of the write that lands at the read edge and of the write
// of the current cycle.
module tspa_tap #(
	parameter int WINDOW_BYTES = tspa_pkg::WINDOW_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(WINDOW_BYTES)-1:0] rd_addr_n,
	input  logic                            wr_en,
	input  logic [$clog2(WINDOW_BYTES)-1:0] wr_addr,
	input  logic [7:0]                      wr_data,
	output logic [7:0]                      rd_data
);

	localparam int AW = $clog2(WINDOW_BYTES);

	logic [AW-1:0] addr_q;
	logic          byp_q;
	logic [7:0]    byp_data_q;
	logic [7:0]    ram_data;

	tspa_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_BYTES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr_n),
		.rd_data (ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			byp_q  <= 1'b0;
		end else begin
			addr_q <= rd_addr_n;
			byp_q  <= wr_en && (wr_addr == rd_addr_n);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wr_data;
	end

	always_comb begin
		if (wr_en && (wr_addr == addr_q)) begin
			rd_data = wr_data;
		end else if (byp_q) begin
			rd_data = byp_data_q;
		end else begin
			rd_data = ram_data;
		end
	end

endmodule

// ----- rtl/ts_packet_sync_aligner.sv -----
// Transport stream sync aligner. Takes one stream byte (or one drain word) per clock and
// returns at most one byte per word, in arrival order, marked kept or dropped, with packet
// start and end flags on kept packets. A word passes through the input register and its
// result through the output register; one word is taken every clock while the output is
// not stalled. The lookahead window is a circular buffer held in four RAM copies, one per
// tap (head, sync of this packet, sync of the next two packets), each read ahead at its
// next address with write forwarding, so no clearing pass is needed after reset.
// packet_size is clamped to 188..208 and should be written only while the block is empty.
module ts_packet_sync_aligner #(
	parameter int WINDOW_BYTES = tspa_pkg::WINDOW_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       kept,
	output logic       packet_start,
	output logic       packet_end
);

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int FW = $clog2(WINDOW_BYTES + 1);
	localparam int NT = tspa_pkg::NUM_TAPS;

	function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
		logic [AW:0] res;
		res = sum;
		if (sum >= (AW + 1)'(WINDOW_BYTES)) begin
			res = sum - (AW + 1)'(WINDOW_BYTES);
		end
		return res[AW-1:0];
	endfunction

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] data_s1;

	// window and alignment state
	logic [7:0]    ps_q;
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic          search_q;
	logic [7:0]    bip_q;
	logic          ended_q;

	// result register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       kept_q;
	logic       start_q;
	logic       end_q;

	logic [7:0]    ps;
	logic [7:0]    ps_n;
	logic [8:0]    need;
	logic          advance;
	logic          commit;
	logic          wr_want;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [FW-1:0] fill_a;
	logic          ended_a;
	logic          pop;
	logic          pop_kept;
	logic          pop_start;
	logic          pop_end;
	logic          search_n;
	logic [7:0]    bip_n;
	logic          chk;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_n;
	logic [8:0]    off_n [NT];
	logic [AW-1:0] rd_addr_n [NT];
	logic [7:0]    tap_data [NT];
	logic          sync0;
	logic          sync1;
	logic          sync2;

	assign ps      = tspa_pkg::clamp_size(ps_q);
	assign ps_n    = tspa_pkg::clamp_size(cfg_wr_en ? cfg_wr_data : ps_q);
	assign need    = tspa_pkg::need_bytes(ps);
	assign advance = !out_valid_q || !out_stall;
	assign commit  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign wr_want = valid_s1 && !kind_s1 && (fill_q != FW'(WINDOW_BYTES));
	assign wr_en   = commit && wr_want;
	assign wr_addr = wrap((AW + 1)'(head_q) + (AW + 1)'(fill_q));

	assign head_inc = wrap((AW + 1)'(head_q) + (AW + 1)'(1));
	assign head_n   = (commit && pop) ? head_inc : head_q;

	assign off_n[0] = '0;
	assign off_n[1] = tspa_pkg::hdr_offset(ps_n);
	assign off_n[2] = tspa_pkg::next_offset(ps_n);
	assign off_n[3] = tspa_pkg::third_offset(ps_n);

	for (genvar t = 0; t < NT; t++) begin : g_tap
		assign rd_addr_n[t] = wrap((AW + 1)'(head_n) + (AW + 1)'(off_n[t]));

		tspa_tap #(
			.WINDOW_BYTES(WINDOW_BYTES)
		) u_tap (
			.clk       (clk),
			.arst_n    (arst_n),
			.rd_addr_n (rd_addr_n[t]),
			.wr_en     (wr_en),
			.wr_addr   (wr_addr),
			.wr_data   (data_s1),
			.rd_data   (tap_data[t])
		);
	end

	assign sync0 = tap_data[1] == tspa_pkg::SYNC_BYTE;
	assign sync1 = tap_data[2] == tspa_pkg::SYNC_BYTE;
	assign sync2 = tap_data[3] == tspa_pkg::SYNC_BYTE;

	always_comb begin
		fill_a    = fill_q + FW'(wr_want);
		ended_a   = ended_q || (valid_s1 && kind_s1);
		pop       = 1'b0;
		pop_kept  = 1'b0;
		pop_start = 1'b0;
		pop_end   = 1'b0;
		search_n  = search_q;
		bip_n     = bip_q;
		chk       = search_q;
		if (fill_a != '0) begin
			if (bip_q != '0) begin
				// inside an accepted packet
				pop      = 1'b1;
				pop_kept = 1'b1;
				pop_end  = ({1'b0, bip_q} + 9'd1) >= {1'b0, ps};
				bip_n    = pop_end ? '0 : bip_q + 8'd1;
			end else begin
				if (!search_q) begin
					if (fill_a >= FW'(ps)) begin
						if (sync0) begin
							pop       = 1'b1;
							pop_kept  = 1'b1;
							pop_start = 1'b1;
							bip_n     = 8'd1;
						end else begin
							// lost lock: fall into the search check
							search_n = 1'b1;
							chk      = 1'b1;
						end
					end else if (ended_a) begin
						pop = 1'b1;
					end
				end
				if (chk) begin
					if (fill_a >= FW'(need)) begin
						pop = 1'b1;
						if (sync0 && sync1 && sync2) begin
							search_n  = 1'b0;
							pop_kept  = 1'b1;
							pop_start = 1'b1;
							bip_n     = 8'd1;
						end
					end else if (ended_a) begin
						pop = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ps_q        <= tspa_pkg::BASE_SIZE;
			head_q      <= '0;
			fill_q      <= '0;
			search_q    <= 1'b0;
			bip_q       <= '0;
			ended_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_wr_en) begin
				ps_q <= cfg_wr_data;
			end
			if (commit) begin
				head_q   <= head_n;
				fill_q   <= fill_a - FW'(pop);
				search_q <= search_n;
				bip_q    <= bip_n;
				ended_q  <= ended_a;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			data_s1 <= data_byte;
		end
		if (commit && pop) begin
			out_byte_q <= tap_data[0];
			kept_q     <= pop_kept;
			start_q    <= pop_start;
			end_q      <= pop_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign kept         = kept_q;
	assign packet_start = start_q;
	assign packet_end   = end_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_BYTES))
		else $error("window fill exceeds depth");

	a_no_search_in_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(bip_q != '0) |-> !search_q)
		else $error("searching while inside a packet");

	a_drop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !kept_q) |-> (!start_q && !end_q))
		else $error("packet flag on a dropped byte");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && pop && pop_start) |=> (bip_q == 8'd1))
		else $error("packet start did not open a packet");

endmodule
